// File: design/bsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

   // Calibration word store.
   localparam int unsigned CalWords  = 8;
   localparam int unsigned CalWidth  = 16;
   localparam int unsigned CalIdxW   = 3;
   localparam int unsigned CsrIndexW = 4;

   // Calibration register indexes.
   localparam int unsigned RegFactory    = 0;
   localparam int unsigned RegPresSens   = 1;
   localparam int unsigned RegPresOffset = 2;
   localparam int unsigned RegSensTco    = 3;
   localparam int unsigned RegOffsetTco  = 4;
   localparam int unsigned RegRefTemp    = 5;
   localparam int unsigned RegTempCoeff  = 6;
   localparam int unsigned RegCrcWord    = 7;

   // Field widths.
   localparam int unsigned RawW  = 24;
   localparam int unsigned TempW = 19;
   localparam int unsigned PresW = 24;

   // Internal arithmetic widths.
   localparam int unsigned DtW      = 25;
   localparam int unsigned ProdW    = 42;
   localparam int unsigned TempSumW = 20;
   localparam int unsigned OffW     = 37;
   localparam int unsigned SensW    = 36;
   localparam int unsigned SensLoW  = 17;
   localparam int unsigned PpLoW    = 41;
   localparam int unsigned PpHiW    = 44;
   localparam int unsigned FullW    = 61;
   localparam int unsigned DiffW    = 41;

   // Pipeline depth, output register included.
   localparam int unsigned NumStages = 6;

   // Compensation constants.
   localparam int signed TempBase = 2000;

   // CRC over the calibration words.
   localparam int unsigned CrcBits  = 4;
   localparam int unsigned CrcMsgW  = CalWords * CalWidth;
   localparam logic [15:0] CrcPoly  = 16'h3000;

   typedef struct packed {
      logic [RawW-1:0] raw_pressure;
      logic [RawW-1:0] raw_temperature;
   } bsc_req_type;

   typedef struct packed {
      logic signed [TempW-1:0] temperature_centi;
      logic signed [PresW-1:0] pressure_centi_mbar;
      logic                    calib_crc_ok;
   } bsc_rsp_type;

   // The CRC is linear in the message bits since the remainder starts at zero.
   // This returns, for one CRC output bit, the set of message bits that feed it.
   // It is evaluated only at elaboration.
   function automatic logic [CrcMsgW-1:0] crc_mask(input int unsigned out_bit);
      logic [CrcMsgW-1:0] mask;
      logic [CrcMsgW-1:0] msg;
      logic [15:0]        rem;
      mask = '0;
      for (int k = 0; k < CrcMsgW; k++) begin
         msg    = '0;
         msg[k] = 1'b1;
         rem    = '0;
         for (int i = 0; i < CrcMsgW / 8; i++) begin
            rem[7:0] = rem[7:0] ^ msg[CrcMsgW-1-8*i -: 8];
            for (int b = 0; b < 8; b++) begin
               if (rem[15]) begin
                  rem = {rem[14:0], 1'b0} ^ CrcPoly;
               end else begin
                  rem = {rem[14:0], 1'b0};
               end
            end
         end
         mask[k] = rem[12+out_bit];
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

// File: design/baro_sensor_compensation.sv
`timescale 1ns / 1ps
`default_nettype none

// Barometric sensor compensation, first-order integer scheme.
//
// Input channel (req_*): one transfer carries a raw pressure and a raw
// temperature conversion. Result channel (rsp_*): one transfer per input,
// carrying temperature in 0.01 degC, pressure in 0.01 mbar and a flag that
// tells whether the CRC over the eight calibration words matches. The user
// writes calibration words through csr_we / csr_index / csr_wdata only while
// no item is in flight (not enforced); indexes past the last word are ignored.
//
// The six register stages are: offset, three multiplies, coefficient sums,
// split pressure product, product merge, and the final subtract and clamp in
// the output register. One item enters per cycle while req_stall is low.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling their empty slots; the input is stalled
// only once every stage holds an item.
// Reset clears all stage valid bits and all calibration words to zero.
module baro_sensor_compensation (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  bsc_pkg::bsc_req_type                 req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output bsc_pkg::bsc_rsp_type                 rsp_data,
   input  wire                                  csr_we,
   input  wire  [bsc_pkg::CsrIndexW-1:0]        csr_index,
   input  wire  [bsc_pkg::CalWidth-1:0]         csr_wdata
);
   import bsc_pkg::*;

   // Calibration words and CRC check.
   logic [CalWidth-1:0]  cal_ff [CalWords];
   logic [CrcMsgW-1:0]   crc_msg;
   logic [CrcBits-1:0]   crc_calc;
   logic                 crc_ok_ff;
   logic                 crc_ok_in;

   // Stage handshake.
   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] load;

   // Stage 0: offset from the reference temperature.
   logic [RawW-1:0]        s0_d1_ff;
   logic signed [DtW-1:0]  s0_dt_ff;
   logic signed [DtW-1:0]  s0_dt_in;

   // Stage 1: the three coefficient products.
   logic [RawW-1:0]          s1_d1_ff;
   logic signed [ProdW-1:0]  s1_tprod_ff, s1_tprod_in;
   logic signed [ProdW-1:0]  s1_oprod_ff, s1_oprod_in;
   logic signed [ProdW-1:0]  s1_sprod_ff, s1_sprod_in;

   // Stage 2: temperature, offset and sensitivity.
   logic [RawW-1:0]            s2_d1_ff;
   logic signed [TempW-1:0]    s2_temp_ff, s2_temp_in;
   logic signed [OffW-1:0]     s2_off_ff, s2_off_in;
   logic signed [SensW-1:0]    s2_sens_ff, s2_sens_in;
   logic signed [TempSumW-1:0] temp_sum;

   // Stage 3: pressure product in two halves.
   logic signed [TempW-1:0]  s3_temp_ff;
   logic signed [OffW-1:0]   s3_off_ff;
   logic [PpLoW-1:0]         s3_pplo_ff, s3_pplo_in;
   logic signed [PpHiW-1:0]  s3_pphi_ff, s3_pphi_in;

   // Stage 4: merged pressure product.
   logic signed [TempW-1:0]  s4_temp_ff;
   logic signed [OffW-1:0]   s4_off_ff;
   logic signed [FullW-1:0]  s4_full_ff, s4_full_in;

   // Stage 5: output register.
   bsc_rsp_type              rsp_ff, rsp_in;
   logic signed [DiffW-1:0]  pres_diff;
   logic signed [DiffW-1:0]  pres_wide;

   // Calibration writes; an index past the last word is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CalWords; i++) begin
            cal_ff[i] <= '0;
         end
      end else if (csr_we && (csr_index < CsrIndexW'(CalWords))) begin
         cal_ff[csr_index[CalIdxW-1:0]] <= csr_wdata;
      end
   end

   // CRC message: all words in order, low byte of the last word taken as zero.
   always_comb begin
      for (int i = 0; i < CalWords; i++) begin
         crc_msg[CrcMsgW-1-CalWidth*i -: CalWidth] = cal_ff[i];
      end
      crc_msg[7:0] = 8'h00;
   end

   for (genvar j = 0; j < CrcBits; j++) begin : g_crc
      localparam logic [CrcMsgW-1:0] Mask = crc_mask(j);
      assign crc_calc[j] = ^(crc_msg & Mask);
   end

   assign crc_ok_in = (crc_calc == cal_ff[RegCrcWord][CrcBits-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ok_ff <= 1'b0;
      end else begin
         crc_ok_ff <= crc_ok_in;
      end
   end

   // A stage loads when it is empty or the stage after it loads.
   always_comb begin
      load[NumStages-1] = !vld_ff[NumStages-1] || !rsp_stall;
      for (int k = NumStages - 2; k >= 0; k--) begin
         load[k] = !vld_ff[k] || load[k+1];
      end
   end

   assign req_stall = !load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (load[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NumStages; k++) begin
            if (load[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // Stage 0 logic: dT = D2 - C5 * 256.
   assign s0_dt_in = signed'({1'b0, req_data.raw_temperature})
                   - signed'({1'b0, cal_ff[RegRefTemp], 8'h00});

   // Stage 1 logic: dT * C6, C4 * dT and C3 * dT.
   assign s1_tprod_in = ProdW'(s0_dt_ff) * ProdW'(signed'({1'b0, cal_ff[RegTempCoeff]}));
   assign s1_oprod_in = ProdW'(s0_dt_ff) * ProdW'(signed'({1'b0, cal_ff[RegOffsetTco]}));
   assign s1_sprod_in = ProdW'(s0_dt_ff) * ProdW'(signed'({1'b0, cal_ff[RegSensTco]}));

   // Stage 2 logic: temperature with clamp, OFF and SENS.
   always_comb begin
      temp_sum = TempSumW'(s1_tprod_ff >>> 23) + TempSumW'(TempBase);
      if (temp_sum[TempSumW-1] != temp_sum[TempSumW-2]) begin
         s2_temp_in = {temp_sum[TempSumW-1], {(TempW-1){!temp_sum[TempSumW-1]}}};
      end else begin
         s2_temp_in = temp_sum[TempW-1:0];
      end
      s2_off_in  = OffW'(signed'({1'b0, cal_ff[RegPresOffset], 17'h00000}))
                 + OffW'(s1_oprod_ff >>> 6);
      s2_sens_in = SensW'(signed'({1'b0, cal_ff[RegPresSens], 16'h0000}))
                 + SensW'(s1_sprod_ff >>> 7);
   end

   // Stage 3 logic: D1 * SENS split into a low unsigned and a high signed part.
   assign s3_pplo_in = PpLoW'(s2_d1_ff) * PpLoW'(s2_sens_ff[SensLoW-1:0]);
   assign s3_pphi_in = PpHiW'(signed'({1'b0, s2_d1_ff}))
                     * PpHiW'($signed(s2_sens_ff[SensW-1:SensLoW]));

   // Stage 4 logic: merge the halves.
   assign s4_full_in = (FullW'(s3_pphi_ff) <<< SensLoW) + FullW'(s3_pplo_ff);

   // Stage 5 logic: pressure = ((D1 * SENS >> 21) - OFF) >> 15, clamped.
   always_comb begin
      pres_diff = DiffW'(s4_full_ff >>> 21) - DiffW'(s4_off_ff);
      pres_wide = pres_diff >>> 15;
      rsp_in.temperature_centi = s4_temp_ff;
      if ((&pres_wide[DiffW-1:PresW-1]) || !(|pres_wide[DiffW-1:PresW-1])) begin
         rsp_in.pressure_centi_mbar = pres_wide[PresW-1:0];
      end else begin
         rsp_in.pressure_centi_mbar = {pres_wide[DiffW-1], {(PresW-1){!pres_wide[DiffW-1]}}};
      end
      rsp_in.calib_crc_ok = crc_ok_ff;
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (load[0]) begin
         s0_d1_ff <= req_data.raw_pressure;
         s0_dt_ff <= s0_dt_in;
      end
      if (load[1]) begin
         s1_d1_ff    <= s0_d1_ff;
         s1_tprod_ff <= s1_tprod_in;
         s1_oprod_ff <= s1_oprod_in;
         s1_sprod_ff <= s1_sprod_in;
      end
      if (load[2]) begin
         s2_d1_ff   <= s1_d1_ff;
         s2_temp_ff <= s2_temp_in;
         s2_off_ff  <= s2_off_in;
         s2_sens_ff <= s2_sens_in;
      end
      if (load[3]) begin
         s3_temp_ff <= s2_temp_ff;
         s3_off_ff  <= s2_off_ff;
         s3_pplo_ff <= s3_pplo_in;
         s3_pphi_ff <= s3_pphi_in;
      end
      if (load[4]) begin
         s4_temp_ff <= s3_temp_ff;
         s4_off_ff  <= s3_off_ff;
         s4_full_ff <= s4_full_in;
      end
      if (load[5]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[NumStages-1];
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: design/bsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bsc_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_stall,
   input wire                   rsp_valid,
   input wire                   rsp_stall,
   input bsc_pkg::bsc_rsp_type  rsp_data
);
   import bsc_pkg::*;

   // A stalled result stays put until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or vanished");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // With the receiver taking results, the input is never stalled.
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output drains");

   // Temperature stays inside the range that any calibration can produce.
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.temperature_centi >= -133072) &&
                    (rsp_data.temperature_centi <= 133072))
      else $error("temperature outside reachable range");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: sim/compensation_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the compensation block and predicts each reading.
// It keeps its own copy of the calibration words from the write port and
// compares every result transfer, field by field, with the oldest prediction.
module compensation_checker (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_stall,
   input  bsc_pkg::bsc_req_type req_data,
   input  wire                  rsp_valid,
   input  wire                  rsp_stall,
   input  bsc_pkg::bsc_rsp_type rsp_data,
   input  wire                  csr_we,
   input  wire  [bsc_pkg::CsrIndexW-1:0] csr_index,
   input  wire  [bsc_pkg::CalWidth-1:0]  csr_wdata,
   output int                   readings_pending,
   output int                   mismatches,
   output int                   readings_checked,
   output int                   crc_match_count
);
   import bsc_pkg::*;

   logic [CalWidth-1:0] cal_shadow [CalWords];
   bsc_rsp_type         expected_readings [$];

   // Clamp a wide signed value into a two's complement field of the given width.
   function automatic longint saturate(input longint value, input int width);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (width - 1)) - 1;
      lo = -hi - 1;
      if (value > hi) begin
         return hi;
      end
      if (value < lo) begin
         return lo;
      end
      return value;
   endfunction

   // CRC-4 over all calibration words, low byte of the last word taken as zero.
   function automatic logic calib_crc_matches();
      logic [15:0] rem;
      logic [15:0] word;
      logic [7:0]  octet;
      rem = '0;
      for (int n = 0; n < 2 * CalWords; n++) begin
         word = cal_shadow[n / 2];
         if (n / 2 == RegCrcWord) begin
            word[7:0] = '0;
         end
         octet = (n % 2 == 1) ? word[7:0] : word[15:8];
         rem[7:0] = rem[7:0] ^ octet;
         for (int b = 0; b < 8; b++) begin
            if (rem[15]) begin
               rem = {rem[14:0], 1'b0} ^ CrcPoly;
            end else begin
               rem = {rem[14:0], 1'b0};
            end
         end
      end
      return rem[15:12] == cal_shadow[RegCrcWord][3:0];
   endfunction

   // First-order compensation; every shift of a signed value rounds toward minus infinity.
   function automatic bsc_rsp_type compensate_sample(input bsc_req_type smp);
      longint d1;
      longint d2;
      longint c1, c2, c3, c4, c5, c6;
      longint dt;
      longint temp;
      longint off;
      longint sens;
      longint pres;
      bsc_rsp_type reading;
      d1 = {40'd0, smp.raw_pressure};
      d2 = {40'd0, smp.raw_temperature};
      c1 = {48'd0, cal_shadow[RegPresSens]};
      c2 = {48'd0, cal_shadow[RegPresOffset]};
      c3 = {48'd0, cal_shadow[RegSensTco]};
      c4 = {48'd0, cal_shadow[RegOffsetTco]};
      c5 = {48'd0, cal_shadow[RegRefTemp]};
      c6 = {48'd0, cal_shadow[RegTempCoeff]};
      dt   = d2 - c5 * 256;
      temp = 2000 + ((dt * c6) >>> 23);
      off  = c2 * 131072 + ((c4 * dt) >>> 6);
      sens = c1 * 65536 + ((c3 * dt) >>> 7);
      pres = (((d1 * sens) >>> 21) - off) >>> 15;
      temp = saturate(temp, TempW);
      pres = saturate(pres, PresW);
      reading.temperature_centi   = temp[TempW-1:0];
      reading.pressure_centi_mbar = pres[PresW-1:0];
      reading.calib_crc_ok        = calib_crc_matches();
      return reading;
   endfunction

   // Retire results first, then queue the prediction for a new sample, then track writes.
   always @(posedge clock) begin : monitor
      bsc_rsp_type want;
      if (reset) begin
         expected_readings.delete();
         for (int i = 0; i < CalWords; i++) begin
            cal_shadow[i] = '0;
         end
         readings_pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: result transfer with nothing expected, actual %h",
                        $time, rsp_data);
               mismatches++;
            end else begin
               want = expected_readings.pop_front();
               readings_checked++;
               if (want.calib_crc_ok) begin
                  crc_match_count++;
               end
               if (rsp_data.temperature_centi !== want.temperature_centi) begin
                  $display("%0t: temperature_centi mismatch, expected %0d, actual %0d",
                           $time, want.temperature_centi, rsp_data.temperature_centi);
                  mismatches++;
               end
               if (rsp_data.pressure_centi_mbar !== want.pressure_centi_mbar) begin
                  $display("%0t: pressure_centi_mbar mismatch, expected %0d, actual %0d",
                           $time, want.pressure_centi_mbar, rsp_data.pressure_centi_mbar);
                  mismatches++;
               end
               if (rsp_data.calib_crc_ok !== want.calib_crc_ok) begin
                  $display("%0t: calib_crc_ok mismatch, expected %b, actual %b",
                           $time, want.calib_crc_ok, rsp_data.calib_crc_ok);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_readings.push_back(compensate_sample(req_data));
         end
         // Indexes past the last calibration word are dropped by the block.
         if (csr_we && csr_index < CalWords) begin
            cal_shadow[csr_index[CalIdxW-1:0]] = csr_wdata;
         end
         readings_pending <= expected_readings.size();
      end
   end

endmodule

// File: sim/baro_sensor_compensation_test.sv
`timescale 1ns / 1ps

// Drives raw conversion pairs and calibration writes into the compensation
// block and reports the verdict from the checker's mismatch count.
module baro_sensor_compensation_test;
   import bsc_pkg::*;

   localparam int HoldCycles = 120;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   bsc_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   bsc_rsp_type rsp_data;
   logic        csr_we;
   logic [CsrIndexW-1:0] csr_index;
   logic [CalWidth-1:0]  csr_wdata;

   int readings_pending;
   int mismatches;
   int readings_checked;
   int crc_match_count;

   // Stall profile and the long output hold request.
   int   send_idle_pct = 0;
   int   rsp_idle_pct  = 0;
   int   hold_left     = 0;
   logic hold_ask      = 1'b0;
   logic hold_taken    = 1'b0;
   int   settings_loaded = 1;

   logic [CalWidth-1:0] plan [CalWords];

   baro_sensor_compensation dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   compensation_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .readings_pending (readings_pending),
      .mismatches       (mismatches),
      .readings_checked (readings_checked),
      .crc_match_count  (crc_match_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Result side: random stalls, or a long counted hold once it is asked for.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_ask && !hold_taken) begin
         rsp_stall  <= 1'b1;
         hold_taken <= 1'b1;
         hold_left  <= HoldCycles;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Offer one sample, with random idle cycles first, and wait for its transfer.
   task automatic send_pair(input logic [RawW-1:0] pres, input logic [RawW-1:0] temp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{raw_pressure: pres, raw_temperature: temp};
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering and wait until every predicted reading has come back.
   task automatic await_empty();
      req_valid <= 1'b0;
      @(posedge clock);
      while (readings_pending != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_word(input int idx, input logic [CalWidth-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= CsrIndexW'(idx);
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Load the planned calibration set, plus a write past the last index.
   task automatic apply_plan();
      for (int i = 0; i < CalWords; i++) begin
         write_word(i, plan[i]);
      end
      write_word($urandom_range(15, CalWords), CalWidth'($urandom));
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   // Mostly random codes, with the rails and values near the operating point mixed in.
   function automatic logic [RawW-1:0] draw_raw(input logic [RawW-1:0] centre);
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return centre + RawW'($urandom_range(4095)) - RawW'(2048);
         default: return RawW'($urandom);
      endcase
   endfunction

   task automatic run_samples(input int count);
      for (int n = 0; n < count; n++) begin
         send_pair(draw_raw(24'd6465444), draw_raw({plan[RegRefTemp], 8'h00}));
      end
   endtask

   // With extremes set, each word is zero, all ones or random; else it is random.
   task automatic plan_mixed(input bit extremes);
      for (int i = 0; i < CalWords; i++) begin
         case (extremes ? $urandom_range(3) : 3)
            0:       plan[i] = '0;
            1:       plan[i] = '1;
            default: plan[i] = CalWidth'($urandom);
         endcase
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the sender idling a quarter of the time.
      send_idle_pct = 25;
      rsp_idle_pct  = 76;

      // Calibration at its reset value: all words zero.
      send_pair(24'h000000, 24'h000000);
      send_pair(24'hFFFFFF, 24'hFFFFFF);
      send_pair(24'hFFFFFF, 24'h000000);
      send_pair(24'h000000, 24'hFFFFFF);
      await_empty();

      // Every word at its maximum.
      for (int i = 0; i < CalWords; i++) begin
         plan[i] = '1;
      end
      apply_plan();
      send_pair(24'h000000, 24'h000000);
      send_pair(24'hFFFFFF, 24'hFFFFFF);
      send_pair(24'hFFFFFF, 24'h000000);
      send_pair(24'h000000, 24'hFFFFFF);
      send_pair(24'hAAAAAA, 24'h555555);
      send_pair(24'h555555, 24'hAAAAAA);
      await_empty();

      // Typical sensor coefficients, including zero and slightly negative dT.
      plan[RegFactory]    = 16'h0000;
      plan[RegPresSens]   = 16'd46372;
      plan[RegPresOffset] = 16'd43981;
      plan[RegSensTco]    = 16'd29059;
      plan[RegOffsetTco]  = 16'd27842;
      plan[RegRefTemp]    = 16'd31553;
      plan[RegTempCoeff]  = 16'd28165;
      plan[RegCrcWord]    = 16'h0003;
      apply_plan();
      send_pair(24'd6465444, 24'd8077636);
      send_pair(24'd6465444, {plan[RegRefTemp], 8'h00});
      send_pair(24'd6465444, {plan[RegRefTemp], 8'h00} - 24'd1);
      send_pair(24'h000000, 24'hFFFFFF);
      send_pair(24'hFFFFFF, 24'h000000);
      await_empty();

      // Largest reference temperature against the lowest raw temperature, and the reverse.
      plan[RegPresSens]   = 16'h0000;
      plan[RegPresOffset] = 16'hFFFF;
      plan[RegSensTco]    = 16'hFFFF;
      plan[RegOffsetTco]  = 16'hFFFF;
      plan[RegRefTemp]    = 16'hFFFF;
      plan[RegTempCoeff]  = 16'hFFFF;
      apply_plan();
      send_pair(24'hFFFFFF, 24'h000000);
      send_pair(24'h000000, 24'h000000);
      await_empty();
      plan[RegRefTemp] = 16'h0000;
      plan[RegPresSens] = 16'hFFFF;
      apply_plan();
      send_pair(24'hFFFFFF, 24'hFFFFFF);
      send_pair(24'h000001, 24'hFFFFFF);
      await_empty();

      // Random settings, sender idles a quarter, receiver three quarters.
      for (int s = 0; s < 2; s++) begin
         plan_mixed(1'b0);
         apply_plan();
         run_samples(65);
         await_empty();
      end

      // Extremes mixed into the settings, and the idle rates swapped.
      send_idle_pct = 76;
      rsp_idle_pct  = 25;
      for (int s = 0; s < 2; s++) begin
         plan_mixed(1'b1);
         apply_plan();
         run_samples(65);
         await_empty();
      end

      // No idling from here on.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;

      // Sweep the expected CRC nibble so that exactly one value matches.
      plan_mixed(1'b0);
      apply_plan();
      for (int nib = 0; nib < 16; nib++) begin
         await_empty();
         write_word(RegCrcWord, {plan[RegCrcWord][15:4], 4'(nib)});
         csr_we <= 1'b0;
         send_pair(draw_raw(24'd6465444), draw_raw({plan[RegRefTemp], 8'h00}));
         send_pair(draw_raw(24'd6465444), draw_raw({plan[RegRefTemp], 8'h00}));
      end
      await_empty();

      // Hold the output long enough that the pipeline fills and backs up the input.
      for (int s = 0; s < 2; s++) begin
         plan_mixed(s == 1);
         apply_plan();
         run_samples(15);
         if (s == 0) begin
            hold_ask <= 1'b1;
         end
         run_samples(40);
         await_empty();
      end

      repeat (2 * NumStages) @(posedge clock);

      $display("Checked %0d compensated samples over %0d calibration settings,",
               readings_checked, settings_loaded);
      $display("three stall profiles and a long output hold; CRC flag set in %0d results.",
               crc_match_count);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
